// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. Define ASSERT_OFF to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define AST_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property whose consequent must hold in the same cycle as the antecedent.
`define AST_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define AST_ALWAYS(lbl, clk, rst_n, prop, msg)
`define AST_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/cpms_pkg.sv =====
// ---------------------------------------------------------------------------
// cpms_pkg
// Types, codes and helper functions shared by the claw pose motion sequencer.
// ---------------------------------------------------------------------------
package cpms_pkg;

  // Action slots per plan; one request produces at most five actions.
  localparam int unsigned MaxOps = 6;
  // Depth of the queue between front and back.
  localparam int unsigned OpQueueDepth = 4;

  localparam logic [7:0]  MaxAngle     = 8'd180;
  localparam logic [10:0] ClosePauseMs = 11'd100;

  // Pose codes, bottom to top.
  localparam logic [2:0] POSE_BOT_OPEN   = 3'd0;
  localparam logic [2:0] POSE_BOT_MID    = 3'd1;
  localparam logic [2:0] POSE_BOT_CLOSED = 3'd2;
  localparam logic [2:0] POSE_SIDE       = 3'd3;
  localparam logic [2:0] POSE_TOP_CLOSED = 3'd4;
  localparam logic [2:0] POSE_TOP_OPEN   = 3'd5;

  // Configuration register indexes.
  localparam logic [2:0] REG_CLOSE_OPEN  = 3'd0;
  localparam logic [2:0] REG_CLOSE_MID   = 3'd1;
  localparam logic [2:0] REG_CLOSE_FIRST = 3'd2;
  localparam logic [2:0] REG_CLOSE_FINAL = 3'd3;
  localparam logic [2:0] REG_LIFT_DOWN   = 3'd4;
  localparam logic [2:0] REG_LIFT_SIDE   = 3'd5;
  localparam logic [2:0] REG_LIFT_UP     = 3'd6;
  localparam logic [2:0] REG_SETTLE      = 3'd7;

  localparam logic SEL_GRIP = 1'b0;
  localparam logic SEL_LIFT = 1'b1;

  typedef enum logic [1:0] {
    ACT_ATTACH = 2'd0,
    ACT_DETACH = 2'd1,
    ACT_RAMP   = 2'd2,
    ACT_SET    = 2'd3
  } action_t;

  // Where an action's target angle comes from.
  typedef enum logic [2:0] {
    SRC_NONE  = 3'd0,
    SRC_OPEN  = 3'd1,
    SRC_MID   = 3'd2,
    SRC_FIRST = 3'd3,
    SRC_FINAL = 3'd4,
    SRC_DOWN  = 3'd5,
    SRC_SIDE  = 3'd6,
    SRC_UP    = 3'd7
  } src_t;

  // Pause that follows an action.
  typedef enum logic [1:0] {
    DW_ZERO   = 2'd0,
    DW_PAUSE  = 2'd1,
    DW_SETTLE = 2'd2,
    DW_DOUBLE = 2'd3
  } dwell_t;

  // One classified action, as passed from front to back.
  typedef struct packed {
    action_t act;
    src_t    src;
    dwell_t  dwell;
    logic    last;
  } op_t;

  // The run of actions for one request.
  typedef struct packed {
    logic [2:0]             cnt;
    op_t [MaxOps-1:0]       ops;
  } plan_t;

  // Configuration register file.
  typedef struct packed {
    logic [7:0] close_open;
    logic [7:0] close_mid;
    logic [7:0] close_first;
    logic [7:0] close_final;
    logic [7:0] lift_down;
    logic [7:0] lift_side;
    logic [7:0] lift_up;
    logic [9:0] settle_ms;
  } cfg_t;

  // One result transaction.
  typedef struct packed {
    action_t     action;
    logic        servo_sel;
    logic [7:0]  angle;
    logic [9:0]  ramp_ms;
    logic [10:0] dwell_ms;
    logic        last_of_run;
  } res_t;

  // Servos clamp commands above full travel.
  function automatic logic [7:0] sat180(input logic [7:0] a);
    sat180 = (a > MaxAngle) ? MaxAngle : a;
  endfunction

  function automatic logic src_is_lift(input src_t s);
    src_is_lift = (s == SRC_DOWN) || (s == SRC_SIDE) || (s == SRC_UP);
  endfunction

endpackage

// ===== rtl/cpms_front.sv =====
// ---------------------------------------------------------------------------
// cpms_front
// Accepts pose requests, classifies them into runs of actions and, while the
// action queue has room, hands it one action per cycle. Tracks current pose.
// ---------------------------------------------------------------------------
module cpms_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [2:0]       in_target_pose,
  input  logic             in_force_req,
  output logic             q_push,
  output cpms_pkg::op_t    q_op,
  input  logic             q_full
);

  // Builds one action descriptor.
  function automatic cpms_pkg::op_t mk_op(input cpms_pkg::action_t act,
                                          input cpms_pkg::src_t src,
                                          input cpms_pkg::dwell_t dw);
    cpms_pkg::op_t o;
    o.act   = act;
    o.src   = src;
    o.dwell = dw;
    o.last  = 1'b0;
    mk_op   = o;
  endfunction

  // Works out the run of actions that moves from pose c to pose t.
  function automatic cpms_pkg::plan_t build_plan(input logic [2:0] c,
                                                 input logic [2:0] t,
                                                 input logic force_req);
    cpms_pkg::plan_t p;
    logic [2:0]      n;
    logic            done;
    p    = '0;
    n    = 3'd0;
    done = 1'b0;
    if (t > cpms_pkg::POSE_TOP_OPEN) begin
      done = 1'b1;
    end else if (t == c) begin
      if (force_req) begin
        // Re-apply the current pose: attach, set jaws, move lift.
        p.ops[n] = mk_op(cpms_pkg::ACT_ATTACH, cpms_pkg::SRC_NONE, cpms_pkg::DW_ZERO);
        n = n + 3'd1;
        if (t == cpms_pkg::POSE_BOT_OPEN || t == cpms_pkg::POSE_TOP_OPEN) begin
          p.ops[n] = mk_op(cpms_pkg::ACT_SET, cpms_pkg::SRC_OPEN, cpms_pkg::DW_ZERO);
        end else if (t == cpms_pkg::POSE_BOT_MID) begin
          p.ops[n] = mk_op(cpms_pkg::ACT_SET, cpms_pkg::SRC_MID, cpms_pkg::DW_ZERO);
        end else begin
          p.ops[n] = mk_op(cpms_pkg::ACT_SET, cpms_pkg::SRC_FINAL, cpms_pkg::DW_ZERO);
        end
        n = n + 3'd1;
        if (t == cpms_pkg::POSE_BOT_OPEN) begin
          p.ops[n] = mk_op(cpms_pkg::ACT_RAMP, cpms_pkg::SRC_DOWN, cpms_pkg::DW_SETTLE);
          n = n + 3'd1;
          // The extra settle pause lands on the detach.
          p.ops[n] = mk_op(cpms_pkg::ACT_DETACH, cpms_pkg::SRC_NONE, cpms_pkg::DW_SETTLE);
        end else if (t <= cpms_pkg::POSE_BOT_CLOSED) begin
          p.ops[n] = mk_op(cpms_pkg::ACT_RAMP, cpms_pkg::SRC_DOWN, cpms_pkg::DW_DOUBLE);
        end else if (t == cpms_pkg::POSE_SIDE) begin
          p.ops[n] = mk_op(cpms_pkg::ACT_RAMP, cpms_pkg::SRC_SIDE, cpms_pkg::DW_DOUBLE);
        end else begin
          p.ops[n] = mk_op(cpms_pkg::ACT_RAMP, cpms_pkg::SRC_UP, cpms_pkg::DW_DOUBLE);
        end
        n = n + 3'd1;
      end
    end else if (t > c) begin
      // Moving upwards.
      if (c == cpms_pkg::POSE_BOT_OPEN) begin
        p.ops[n] = mk_op(cpms_pkg::ACT_ATTACH, cpms_pkg::SRC_NONE, cpms_pkg::DW_ZERO);
        n = n + 3'd1;
        if (t == cpms_pkg::POSE_BOT_MID) begin
          p.ops[n] = mk_op(cpms_pkg::ACT_RAMP, cpms_pkg::SRC_MID, cpms_pkg::DW_SETTLE);
          n = n + 3'd1;
          done = 1'b1;
        end
      end
      if (!done && c <= cpms_pkg::POSE_BOT_MID) begin
        p.ops[n] = mk_op(cpms_pkg::ACT_RAMP, cpms_pkg::SRC_FIRST, cpms_pkg::DW_PAUSE);
        n = n + 3'd1;
        p.ops[n] = mk_op(cpms_pkg::ACT_SET, cpms_pkg::SRC_FINAL, cpms_pkg::DW_SETTLE);
        n = n + 3'd1;
        if (t == cpms_pkg::POSE_BOT_CLOSED) begin
          done = 1'b1;
        end
      end
      if (!done && c <= cpms_pkg::POSE_BOT_CLOSED && t == cpms_pkg::POSE_SIDE) begin
        p.ops[n] = mk_op(cpms_pkg::ACT_RAMP, cpms_pkg::SRC_SIDE, cpms_pkg::DW_SETTLE);
        n = n + 3'd1;
        done = 1'b1;
      end
      if (!done && c <= cpms_pkg::POSE_SIDE) begin
        p.ops[n] = mk_op(cpms_pkg::ACT_RAMP, cpms_pkg::SRC_UP, cpms_pkg::DW_SETTLE);
        n = n + 3'd1;
        if (t == cpms_pkg::POSE_TOP_CLOSED) begin
          done = 1'b1;
        end
      end
      if (!done) begin
        p.ops[n] = mk_op(cpms_pkg::ACT_RAMP, cpms_pkg::SRC_OPEN, cpms_pkg::DW_SETTLE);
        n = n + 3'd1;
      end
    end else begin
      // Moving downwards.
      if (c == cpms_pkg::POSE_TOP_OPEN) begin
        p.ops[n] = mk_op(cpms_pkg::ACT_RAMP, cpms_pkg::SRC_FIRST, cpms_pkg::DW_PAUSE);
        n = n + 3'd1;
        p.ops[n] = mk_op(cpms_pkg::ACT_SET, cpms_pkg::SRC_FINAL, cpms_pkg::DW_SETTLE);
        n = n + 3'd1;
        if (t == cpms_pkg::POSE_TOP_CLOSED) begin
          done = 1'b1;
        end
      end
      if (!done && c >= cpms_pkg::POSE_TOP_CLOSED && t == cpms_pkg::POSE_SIDE) begin
        p.ops[n] = mk_op(cpms_pkg::ACT_RAMP, cpms_pkg::SRC_SIDE, cpms_pkg::DW_SETTLE);
        n = n + 3'd1;
        done = 1'b1;
      end
      if (!done && c >= cpms_pkg::POSE_SIDE) begin
        p.ops[n] = mk_op(cpms_pkg::ACT_RAMP, cpms_pkg::SRC_DOWN, cpms_pkg::DW_SETTLE);
        n = n + 3'd1;
        if (t == cpms_pkg::POSE_BOT_CLOSED) begin
          done = 1'b1;
        end
      end
      if (!done && c >= cpms_pkg::POSE_BOT_CLOSED && t == cpms_pkg::POSE_BOT_MID) begin
        p.ops[n] = mk_op(cpms_pkg::ACT_RAMP, cpms_pkg::SRC_MID, cpms_pkg::DW_SETTLE);
        n = n + 3'd1;
        done = 1'b1;
      end
      if (!done) begin
        p.ops[n] = mk_op(cpms_pkg::ACT_RAMP, cpms_pkg::SRC_OPEN, cpms_pkg::DW_SETTLE);
        n = n + 3'd1;
        p.ops[n] = mk_op(cpms_pkg::ACT_DETACH, cpms_pkg::SRC_NONE, cpms_pkg::DW_ZERO);
        n = n + 3'd1;
      end
    end
    p.cnt      = n;
    build_plan = p;
  endfunction

  logic            busy_r, busy_nxt;
  logic [2:0]      pose_r, pose_nxt;
  logic [2:0]      idx_r, idx_nxt;
  cpms_pkg::plan_t plan_r, plan_nxt;
  cpms_pkg::plan_t new_plan;
  logic            accept;
  logic            op_fire;
  logic            last_fire;

  // Classification of the incoming request.
  assign new_plan = build_plan(pose_r, in_target_pose, in_force_req);

  // Hand-off of one action per cycle to the queue while it is not full.
  assign op_fire   = busy_r && !q_full;
  assign last_fire = op_fire && (idx_r == (plan_r.cnt - 3'd1));
  assign full      = busy_r && !last_fire;
  assign accept    = push && !full;
  assign q_push    = busy_r;

  always_comb begin
    q_op      = plan_r.ops[idx_r];
    q_op.last = (idx_r == (plan_r.cnt - 3'd1));
  end

  // Request sequencing.
  always_comb begin
    busy_nxt = busy_r;
    pose_nxt = pose_r;
    idx_nxt  = idx_r;
    plan_nxt = plan_r;
    if (accept) begin
      plan_nxt = new_plan;
      idx_nxt  = 3'd0;
      busy_nxt = (new_plan.cnt != 3'd0);
      if (in_target_pose <= cpms_pkg::POSE_TOP_OPEN) begin
        pose_nxt = in_target_pose;
      end
    end else if (last_fire) begin
      busy_nxt = 1'b0;
    end else if (op_fire) begin
      idx_nxt = idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pose_r <= cpms_pkg::POSE_TOP_OPEN;
      idx_r  <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      pose_r <= pose_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    plan_r <= plan_nxt;
  end

endmodule

// ===== rtl/cpms_op_queue.sv =====
// ---------------------------------------------------------------------------
// cpms_op_queue
// Short first-in first-out queue of classified actions between front and back.
// ---------------------------------------------------------------------------
module cpms_op_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  cpms_pkg::op_t wr_op,
  output logic          q_full,
  input  logic          rd_en,
  output cpms_pkg::op_t rd_op,
  output logic          q_empty
);

  localparam int unsigned PtrW = $clog2(cpms_pkg::OpQueueDepth);

  cpms_pkg::op_t       mem_r [cpms_pkg::OpQueueDepth];
  logic [PtrW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [PtrW:0]       cnt_r, cnt_nxt;
  logic                do_wr;
  logic                do_rd;

  assign q_full  = (cnt_r == (PtrW+1)'(cpms_pkg::OpQueueDepth));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_op   = mem_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_op;
    end
  end

endmodule

// ===== rtl/cpms_back.sv =====
// ---------------------------------------------------------------------------
// cpms_back
// Carries out queued actions: resolves angles, ramp times and pauses, tracks
// the last commanded servo angles and buffers results for the receiver.
// ---------------------------------------------------------------------------
module cpms_back (
  input  logic           clk,
  input  logic           rst_n,
  input  cpms_pkg::cfg_t cfg,
  input  logic           q_empty,
  input  cpms_pkg::op_t  q_op,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output cpms_pkg::res_t res
);

  cpms_pkg::res_t buf_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     cnt_r, cnt_nxt;
  logic [7:0]     grip_r, grip_nxt;
  logic [7:0]     lift_r, lift_nxt;
  logic           res_pop;
  logic           is_lift;
  logic [7:0]     raw_angle;
  logic [7:0]     tgt;
  logic [7:0]     prev;
  logic [7:0]     delta;
  logic [10:0]    dwell;
  cpms_pkg::res_t new_res;

  // Result buffer status; a slot frees up when the receiver pops this cycle.
  assign empty   = (cnt_r == 2'd0);
  assign res_pop = pop && !empty;
  assign q_pop   = !q_empty && ((cnt_r != 2'd2) || res_pop);
  assign res     = buf_r[rd_ptr_r];

  // Target angle from the configuration registers.
  always_comb begin
    case (q_op.src)
      cpms_pkg::SRC_OPEN:  raw_angle = cfg.close_open;
      cpms_pkg::SRC_MID:   raw_angle = cfg.close_mid;
      cpms_pkg::SRC_FIRST: raw_angle = cfg.close_first;
      cpms_pkg::SRC_FINAL: raw_angle = cfg.close_final;
      cpms_pkg::SRC_DOWN:  raw_angle = cfg.lift_down;
      cpms_pkg::SRC_SIDE:  raw_angle = cfg.lift_side;
      cpms_pkg::SRC_UP:    raw_angle = cfg.lift_up;
      default:             raw_angle = 8'd0;
    endcase
  end

  // Pause after the action.
  always_comb begin
    case (q_op.dwell)
      cpms_pkg::DW_ZERO:   dwell = 11'd0;
      cpms_pkg::DW_PAUSE:  dwell = cpms_pkg::ClosePauseMs;
      cpms_pkg::DW_SETTLE: dwell = {1'b0, cfg.settle_ms};
      cpms_pkg::DW_DOUBLE: dwell = {cfg.settle_ms, 1'b0};
      default:             dwell = 11'd0;
    endcase
  end

  assign is_lift = cpms_pkg::src_is_lift(q_op.src);
  assign tgt     = cpms_pkg::sat180(raw_angle);
  assign prev    = is_lift ? lift_r : grip_r;
  assign delta   = (prev > tgt) ? (prev - tgt) : (tgt - prev);

  // Result fields and servo angle tracking.
  always_comb begin
    new_res             = '0;
    new_res.action      = q_op.act;
    new_res.dwell_ms    = dwell;
    new_res.last_of_run = q_op.last;
    grip_nxt            = grip_r;
    lift_nxt            = lift_r;
    if (q_op.act == cpms_pkg::ACT_RAMP || q_op.act == cpms_pkg::ACT_SET) begin
      new_res.servo_sel = is_lift ? cpms_pkg::SEL_LIFT : cpms_pkg::SEL_GRIP;
      new_res.angle     = tgt;
      if (q_op.act == cpms_pkg::ACT_RAMP) begin
        new_res.ramp_ms = {delta, 2'b00};
      end
      if (q_pop) begin
        if (is_lift) begin
          lift_nxt = tgt;
        end else begin
          grip_nxt = tgt;
        end
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_pop && !res_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (res_pop && !q_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      grip_r   <= 8'd90;
      lift_r   <= 8'd90;
    end else begin
      cnt_r    <= cnt_nxt;
      wr_ptr_r <= q_pop ? ~wr_ptr_r : wr_ptr_r;
      rd_ptr_r <= res_pop ? ~rd_ptr_r : rd_ptr_r;
      grip_r   <= grip_nxt;
      lift_r   <= lift_nxt;
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      buf_r[wr_ptr_r] <= new_res;
    end
  end

endmodule

// ===== rtl/claw_pose_motion_sequencer_unit.sv =====
// ---------------------------------------------------------------------------
// claw_pose_motion_sequencer_unit
// Turns pose requests for a two-servo gripper into runs of servo actions.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: a pose request (target pose, force flag) is taken on a
//   clock edge with push high and full low. Output channel: while empty is
//   low the oldest action is on the out_ ports; pop high takes it.
//   A request yields zero to five actions; out_last_of_run marks the final
//   one. A request for the current pose without force, or an invalid pose,
//   yields nothing.
//   Each action is registered in the action queue, then the result buffer,
//   before it reaches the out_ ports. The front hands one action per cycle to
//   the queue while it has room; full stays high until a request's last action
//   goes, and the next request can be taken in that cycle. With pop high the
//   back delivers one action per cycle while the queue is not empty. The user
//   writes the configuration registers through cfg_wr_en, cfg_index and
//   cfg_wdata only while the block is idle; the block does not enforce it.
//   Reset: current pose is top open, both servo angles 90, registers at
//   their defaults, all queues empty. When the receiver stalls, the result
//   buffer and the action queue fill and full then holds off new requests.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module claw_pose_motion_sequencer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  in_target_pose,
  input  logic        in_force_req,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_action,
  output logic        out_servo_sel,
  output logic [7:0]  out_angle,
  output logic [9:0]  out_ramp_ms,
  output logic [10:0] out_dwell_ms,
  output logic        out_last_of_run,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_wdata
);

  cpms_pkg::cfg_t cfg_r, cfg_nxt;
  cpms_pkg::op_t  fq_op;
  cpms_pkg::op_t  qb_op;
  cpms_pkg::res_t res;
  logic           fq_push;
  logic           fq_full;
  logic           qb_pop;
  logic           qb_empty;

  // Configuration register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        cpms_pkg::REG_CLOSE_OPEN:  cfg_nxt.close_open  = cfg_wdata[7:0];
        cpms_pkg::REG_CLOSE_MID:   cfg_nxt.close_mid   = cfg_wdata[7:0];
        cpms_pkg::REG_CLOSE_FIRST: cfg_nxt.close_first = cfg_wdata[7:0];
        cpms_pkg::REG_CLOSE_FINAL: cfg_nxt.close_final = cfg_wdata[7:0];
        cpms_pkg::REG_LIFT_DOWN:   cfg_nxt.lift_down   = cfg_wdata[7:0];
        cpms_pkg::REG_LIFT_SIDE:   cfg_nxt.lift_side   = cfg_wdata[7:0];
        cpms_pkg::REG_LIFT_UP:     cfg_nxt.lift_up     = cfg_wdata[7:0];
        cpms_pkg::REG_SETTLE:      cfg_nxt.settle_ms   = cfg_wdata;
        default:                   cfg_nxt             = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.close_open  <= 8'd0;
      cfg_r.close_mid   <= 8'd45;
      cfg_r.close_first <= 8'd150;
      cfg_r.close_final <= 8'd170;
      cfg_r.lift_down   <= 8'd0;
      cfg_r.lift_side   <= 8'd90;
      cfg_r.lift_up     <= 8'd180;
      cfg_r.settle_ms   <= 10'd200;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: request classification.
  cpms_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_target_pose (in_target_pose),
    .in_force_req   (in_force_req),
    .q_push         (fq_push),
    .q_op           (fq_op),
    .q_full         (fq_full)
  );

  // Action queue between front and back.
  cpms_op_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fq_push),
    .wr_op   (fq_op),
    .q_full  (fq_full),
    .rd_en   (qb_pop),
    .rd_op   (qb_op),
    .q_empty (qb_empty)
  );

  // Back: action execution and result buffering.
  cpms_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (qb_empty),
    .q_op    (qb_op),
    .q_pop   (qb_pop),
    .empty   (empty),
    .pop     (pop),
    .res     (res)
  );

  assign out_action      = res.action;
  assign out_servo_sel   = res.servo_sel;
  assign out_angle       = res.angle;
  assign out_ramp_ms     = res.ramp_ms;
  assign out_dwell_ms    = res.dwell_ms;
  assign out_last_of_run = res.last_of_run;

  // Attach and detach transactions carry no angle, ramp time or servo select.
  `AST_ALWAYS(a_attach_clean, clk, rst_n, empty || (out_action == cpms_pkg::ACT_RAMP) || (out_action == cpms_pkg::ACT_SET) || (out_angle == 8'd0 && out_ramp_ms == 10'd0 && !out_servo_sel), "attach or detach with payload")
  // Immediate sets never report a ramp time.
  `AST_ALWAYS(a_set_no_ramp, clk, rst_n, empty || (out_action != cpms_pkg::ACT_SET) || (out_ramp_ms == 10'd0), "set with ramp time")
  // Angles are saturated and ramp times follow from them.
  `AST_ALWAYS(a_angle_range, clk, rst_n, empty || (out_angle <= cpms_pkg::MaxAngle && out_ramp_ms <= 10'd720), "angle or ramp time out of range")
  // The back only takes an action that the queue holds.
  `AST_ALWAYS(a_queue_pop, clk, rst_n, !qb_pop || !qb_empty, "action taken from empty queue")

endmodule
